// File: rtl/cd420_pkg.sv
// Shared types and constants of the 4:2:0 chroma downsampler.
package cd420_pkg;

	localparam int DIM_W = 13;
	localparam int ROW_W = 12;
	localparam int SAMPLE_W = 8;
	localparam int PAIR_W = 9;

	localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 13'd4096;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		MODE_QUAD = 2'd0,
		MODE_VERT = 2'd1,
		MODE_HORZ = 2'd2,
		MODE_PASS = 2'd3
	} mode_t;

	typedef struct packed {
		logic odd_row;
		logic odd_col;
		logic last_row;
		logic last_col;
	} pos_t;

endpackage

// File: rtl/cd420_ram.sv
// Generic simple dual-port RAM with registered read.
module cd420_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 2048
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/cd420_pos.sv
// Column and row counters with frame-size clamping and position flags.
module cd420_pos #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic [cd420_pkg::DIM_W-1:0]         frame_width,
	input  logic [cd420_pkg::DIM_W-1:0]         frame_height,
	output logic [(((MAX_WIDTH + 1) / 2) > 1 ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0] idx,
	output cd420_pkg::pos_t                     pos
);

	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = WW > cd420_pkg::DIM_W ? WW : cd420_pkg::DIM_W;
	localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

	logic [CW-1:0]               col_q;
	logic [cd420_pkg::ROW_W-1:0] row_q;
	logic [EW-1:0]               fw_ext;
	logic [EW-1:0]               w_eff;
	logic [cd420_pkg::DIM_W-1:0] h_eff;

	assign fw_ext = EW'(frame_width);

	always_comb begin
		if (fw_ext == '0) begin
			w_eff = EW'(1);
		end else if (fw_ext > MAX_W) begin
			w_eff = MAX_W;
		end else begin
			w_eff = fw_ext;
		end
		if (frame_height == '0) begin
			h_eff = cd420_pkg::DIM_W'(1);
		end else if (frame_height > cd420_pkg::HEIGHT_LIMIT) begin
			h_eff = cd420_pkg::HEIGHT_LIMIT;
		end else begin
			h_eff = frame_height;
		end
	end

	assign pos.last_col = (EW'(col_q) + EW'(1)) >= w_eff;
	assign pos.last_row = (cd420_pkg::DIM_W'(row_q) + cd420_pkg::DIM_W'(1)) >= h_eff;
	assign pos.odd_col = col_q[0];
	assign pos.odd_row = row_q[0];
	assign idx = AW'(col_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (pos.last_col) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row_q + cd420_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

// File: rtl/chroma_downsample_420_unit.sv
// 4:2:0 chroma downsampler: raster samples in, subsampled plane out.
// A result is registered in stage one, then in the output register, after the sample that completes its block.
// Throughput: one sample per cycle while the output is not stalled; each sample makes at most one line-store access.
// Reset clears counters, left sample, pipeline valids and sets size to 640x480.
// The line store is not cleared; even rows fill it before odd rows read it.
module chroma_downsample_420_unit #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic [7:0]  sample,
	input  logic        sample_valid,
	output logic        sample_ready,
	output logic [7:0]  value,
	output logic        last,
	output logic        result_valid,
	input  logic        result_ready
);

	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;

	logic [cd420_pkg::DIM_W-1:0]    width_q;
	logic [cd420_pkg::DIM_W-1:0]    height_q;
	logic [cd420_pkg::SAMPLE_W-1:0] left_q;
	cd420_pkg::pos_t                pos;
	logic [AW-1:0]                  idx;
	logic                           accept;
	logic                           out_adv;
	logic                           emit;
	logic                           mem_we;
	logic                           mem_re;
	logic [cd420_pkg::PAIR_W-1:0]   lr_sum;
	logic [cd420_pkg::PAIR_W-1:0]   mem_wdata;
	logic [cd420_pkg::PAIR_W-1:0]   mem_rdata;
	cd420_pkg::mode_t               mode;
	logic [cd420_pkg::PAIR_W-1:0]   part;
	logic                           valid_s1;
	cd420_pkg::mode_t               mode_s1;
	logic [cd420_pkg::PAIR_W-1:0]   part_s1;
	logic                           last_s1;
	logic [cd420_pkg::PAIR_W:0]     sum_s1;
	logic [cd420_pkg::SAMPLE_W-1:0] res_s1;
	logic                           out_valid_q;
	logic [cd420_pkg::SAMPLE_W-1:0] value_q;
	logic                           last_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= cd420_pkg::WIDTH_RESET;
			height_q <= cd420_pkg::HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				cd420_pkg::REG_WIDTH: width_q <= pwdata[cd420_pkg::DIM_W-1:0];
				cd420_pkg::REG_HEIGHT: height_q <= pwdata[cd420_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			cd420_pkg::REG_WIDTH: prdata = 32'(width_q);
			cd420_pkg::REG_HEIGHT: prdata = 32'(height_q);
			default: prdata = '0;
		endcase
	end

	cd420_pos #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.advance(accept),
		.frame_width(width_q),
		.frame_height(height_q),
		.idx(idx),
		.pos(pos)
	);

	assign out_adv = !out_valid_q || result_ready;
	assign sample_ready = !valid_s1 || out_adv;
	assign accept = sample_valid && sample_ready;

	assign lr_sum = cd420_pkg::PAIR_W'(left_q) + cd420_pkg::PAIR_W'(sample);
	assign emit = (pos.odd_row || pos.last_row) && (pos.odd_col || pos.last_col);
	assign mem_we = accept && !pos.odd_row && !pos.last_row && (pos.odd_col || pos.last_col);
	assign mem_re = accept && pos.odd_row && (pos.odd_col || pos.last_col);
	assign mem_wdata = pos.odd_col ? lr_sum : cd420_pkg::PAIR_W'(sample);

	always_comb begin
		if (pos.odd_row) begin
			mode = pos.odd_col ? cd420_pkg::MODE_QUAD : cd420_pkg::MODE_VERT;
		end else begin
			mode = pos.odd_col ? cd420_pkg::MODE_HORZ : cd420_pkg::MODE_PASS;
		end
		part = pos.odd_col ? lr_sum : cd420_pkg::PAIR_W'(sample);
	end

	cd420_ram #(
		.WIDTH(cd420_pkg::PAIR_W),
		.DEPTH(DEPTH)
	) u_line (
		.clk(clk),
		.we(mem_we),
		.waddr(idx),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(idx),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (accept && !pos.odd_col && !pos.last_col) begin
			left_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			part_s1 <= part;
			last_s1 <= pos.last_col && pos.last_row;
		end
	end

	assign sum_s1 = (cd420_pkg::PAIR_W + 1)'(mem_rdata) + (cd420_pkg::PAIR_W + 1)'(part_s1);

	always_comb begin
		case (mode_s1)
			cd420_pkg::MODE_QUAD: res_s1 = sum_s1[9:2];
			cd420_pkg::MODE_VERT: res_s1 = sum_s1[8:1];
			cd420_pkg::MODE_HORZ: res_s1 = part_s1[8:1];
			cd420_pkg::MODE_PASS: res_s1 = part_s1[7:0];
			default: res_s1 = part_s1[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			value_q <= res_s1;
			last_q <= last_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign value = value_q;
	assign last = last_q;

`ifndef SYNTHESIS
	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("line store read and write in one cycle");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_adv |=> valid_s1 && $stable(part_s1))
		else $error("stalled stage-one word lost");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos.last_col && pos.last_row |=> !pos.odd_row && !pos.odd_col)
		else $error("counters did not wrap at frame end");
`endif

endmodule

// File: test/chroma_downsample_420_unit_tb.sv
// Self-checking testbench for the 4:2:0 chroma downsampler.
`timescale 1ns / 1ps

module chroma_downsample_420_unit_tb;

	localparam int MAX_W = 4096;
	localparam int STORE_DEPTH = (MAX_W + 1) / 2;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 520;
	localparam int WIDE_W = 160;
	localparam int TALL_H = 160;

	typedef struct packed {
		logic [cd420_pkg::SAMPLE_W-1:0] value;
		logic                           last;
	} chroma_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic [7:0]  sample = '0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	logic [7:0]  value;
	logic        last;
	logic        result_valid;
	logic        result_ready = 1'b0;

	chroma_downsample_420_unit #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample(sample),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.value(value),
		.last(last),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the block's registers and state
	logic [cd420_pkg::DIM_W-1:0]    width_cfg = cd420_pkg::WIDTH_RESET;
	logic [cd420_pkg::DIM_W-1:0]    height_cfg = cd420_pkg::HEIGHT_RESET;
	logic [cd420_pkg::PAIR_W-1:0]   pair_store [STORE_DEPTH];
	logic [cd420_pkg::ROW_W-1:0]    col_pos = '0;
	logic [cd420_pkg::ROW_W-1:0]    row_pos = '0;
	logic [cd420_pkg::SAMPLE_W-1:0] left_pix = '0;

	chroma_out_t subsampled_q [$];
	chroma_out_t want_out;
	int mismatch_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_max = 8;
	int stall_max = 6;
	int rx_left = 0;
	bit rx_open = 1'b1;

	function automatic int eff_dim(input logic [cd420_pkg::DIM_W-1:0] r, input int lim);
		if (r == 0)
			return 1;
		if (int'(r) > lim)
			return lim;
		return int'(r);
	endfunction

	task automatic report(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic predict_subsample(input logic [cd420_pkg::SAMPLE_W-1:0] s);
		int w;
		int h;
		int idx;
		int v;
		bit col_end;
		bit row_end;
		bit emit;
		chroma_out_t item;
		w = eff_dim(width_cfg, MAX_W);
		h = eff_dim(height_cfg, int'(cd420_pkg::HEIGHT_LIMIT));
		col_end = (int'(col_pos) + 1 >= w);
		row_end = (int'(row_pos) + 1 >= h);
		idx = int'(col_pos >> 1) % STORE_DEPTH;
		emit = 1'b0;
		v = 0;
		if (!row_pos[0] && !row_end) begin
			if (col_pos[0])
				pair_store[idx] = {1'b0, left_pix} + {1'b0, s};
			else if (col_end)
				pair_store[idx] = {1'b0, s};
			else
				left_pix = s;
		end else if (row_pos[0]) begin
			if (col_pos[0]) begin
				v = (int'(pair_store[idx]) + int'(left_pix) + int'(s)) / 4;
				emit = 1'b1;
			end else if (col_end) begin
				v = (int'(pair_store[idx]) + int'(s)) / 2;
				emit = 1'b1;
			end else begin
				left_pix = s;
			end
		end else begin
			if (col_pos[0]) begin
				v = (int'(left_pix) + int'(s)) / 2;
				emit = 1'b1;
			end else if (col_end) begin
				v = int'(s);
				emit = 1'b1;
			end else begin
				left_pix = s;
			end
		end
		if (emit) begin
			item.value = v[cd420_pkg::SAMPLE_W-1:0];
			item.last = col_end && row_end;
			subsampled_q.push_back(item);
		end
		if (col_end) begin
			col_pos = '0;
			row_pos = row_end ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready)
				predict_subsample(sample);
			if (result_valid && result_ready) begin
				if (subsampled_q.size() == 0) begin
					report($sformatf("unexpected word value=%0d last=%0b", value, last));
				end else begin
					want_out = subsampled_q.pop_front();
					if (value !== want_out.value)
						report($sformatf("value %0d, want %0d", value, want_out.value));
					if (last !== want_out.last)
						report($sformatf("last %0b, want %0b", last, want_out.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_open = !rx_open || (stall_max == 0);
			if (rx_open)
				rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 12);
			else
				rx_left = $urandom_range(1, stall_max);
			result_ready <= rx_open;
		end
		rx_left--;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_sample(input logic [cd420_pkg::SAMPLE_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		sample <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic wait_drain();
		sample_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (subsampled_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic sel, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (sel == cd420_pkg::REG_WIDTH)
			width_cfg = data[cd420_pkg::DIM_W-1:0];
		else
			height_cfg = data[cd420_pkg::DIM_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read_check(input logic sel, input logic [cd420_pkg::DIM_W-1:0] want);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== {{(32-cd420_pkg::DIM_W){1'b0}}, want})
			report($sformatf("register %0d reads %0d, want %0d", sel, got, want));
	endtask

	task automatic set_size(input int w_reg, input int h_reg);
		wait_drain();
		reg_write(cd420_pkg::REG_WIDTH, 32'(w_reg));
		reg_write(cd420_pkg::REG_HEIGHT, 32'(h_reg));
		reg_read_check(cd420_pkg::REG_WIDTH, width_cfg);
		reg_read_check(cd420_pkg::REG_HEIGHT, height_cfg);
	endtask

	function automatic logic [cd420_pkg::SAMPLE_W-1:0] pick_sample(input int style);
		case (style)
			0: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			1: return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(240, 255))
				: 8'($urandom_range(0, 15));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic test_reset_size_midframe();
		reg_read_check(cd420_pkg::REG_WIDTH, cd420_pkg::WIDTH_RESET);
		reg_read_check(cd420_pkg::REG_HEIGHT, cd420_pkg::HEIGHT_RESET);
		repeat (3) send_sample(8'hFF);
		// shrink below the current column: wraps into a 3x2 frame
		set_size(3, 2);
		send_sample(8'hFF);
		send_sample(8'hFF);
		send_sample(8'hFF);
		send_sample(8'h00);
	endtask

	task automatic test_zero_size();
		set_size(0, 0);
		send_sample(8'h00);
		send_sample(8'hFF);
	endtask

	task automatic test_odd_corner();
		logic [cd420_pkg::SAMPLE_W-1:0] px [9];
		px = '{8'h01, 8'h02, 8'h80, 8'h7F, 8'hFE, 8'h03, 8'h55, 8'hAA, 8'hFF};
		set_size(3, 3);
		foreach (px[i])
			send_sample(px[i]);
	endtask

	task automatic test_oversize_width();
		set_size(8191, 1);
		repeat (4) send_sample(pick_sample(2));
		set_size(2, 1);
		send_sample(8'hC3);
	endtask

	task automatic test_oversize_height();
		set_size(1, 8191);
		repeat (3) send_sample(pick_sample(2));
		set_size(1, 1);
		send_sample(8'h3C);
	endtask

	task automatic test_large_frames();
		gap_max = 2;
		stall_max = 3;
		set_size(WIDE_W, 2);
		repeat (2 * WIDE_W) send_sample(pick_sample(2));
		set_size(1, TALL_H);
		repeat (TALL_H) send_sample(pick_sample(2));
	endtask

	task automatic test_random_frames();
		int sent;
		int w_reg;
		int h_reg;
		int style;
		int frame_items;
		bit first;
		sent = 0;
		first = 1'b1;
		w_reg = 1;
		h_reg = 1;
		while (sent < RANDOM_ITEMS) begin
			if (first || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0: begin
						w_reg = $urandom_range(13, 64);
						h_reg = $urandom_range(1, 4);
					end
					1: begin
						w_reg = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 6);
						h_reg = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 6);
					end
					default: begin
						w_reg = $urandom_range(1, 12);
						h_reg = $urandom_range(1, 8);
					end
				endcase
				gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				stall_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				set_size(w_reg, h_reg);
				first = 1'b0;
			end
			style = $urandom_range(0, 4);
			frame_items = eff_dim(cd420_pkg::DIM_W'(w_reg), MAX_W)
				* eff_dim(cd420_pkg::DIM_W'(h_reg), int'(cd420_pkg::HEIGHT_LIMIT));
			repeat (frame_items) begin
				send_sample(pick_sample(style));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size_midframe();
		test_zero_size();
		test_odd_corner();
		test_oversize_width();
		test_oversize_height();
		test_large_frames();
		test_random_frames();
		wait_drain();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/cd420_pkg.sv
rtl/cd420_ram.sv
rtl/cd420_pos.sv
rtl/chroma_downsample_420_unit.sv
test/chroma_downsample_420_unit_tb.sv
